// ----- rtl/core/gtr_pkg.sv -----
// Package: shared types, constants and codes of the gyro timestamp regularizer.
package gtr_pkg;

   localparam int TimeWidth = 63;
   localparam logic [62:0] TMax = {63{1'b1}};
   localparam logic [19:0] NsPerMs = 20'd1000000;
   localparam logic [62:0] NearSlackNs = 63'd500000;
   localparam logic [62:0] MinGapTestNs = 63'd2500000;
   localparam logic [62:0] MinGapNs = 63'd2600000;
   localparam logic signed [16:0] RateLimit = 17'sd28571;
   localparam logic [9:0] PeriodReset = 10'd200;

   localparam logic [1:0] KindStart = 2'd0;
   localparam logic [1:0] KindTick = 2'd1;
   localparam logic [1:0] KindSample = 2'd2;
   localparam logic [1:0] KindUnused = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [62:0] time_ns;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
      logic signed [15:0] bias_x;
      logic signed [15:0] bias_y;
      logic signed [15:0] bias_z;
      logic [7:0] accuracy;
      logic bias_mode;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic [7:0] out_accuracy;
      logic [62:0] out_time_ns;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture item, compute period
      logic div_start; // begin quotient
      logic div_step;  // one quotient bit
      logic mul_step;  // one product bit
      logic finish;    // update state, form result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic needs_div;
      logic emit;
      logic is_none;
   } sts_type;

endpackage

// ----- rtl/core/gtr_datapath.sv -----
// Datapath: item registers, bit-serial divider and multiplier, state update.
module gtr_datapath (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic [9:0] csr_wdata,
   input gtr_pkg::req_type req_item,
   input gtr_pkg::cmd_type cmd,
   output gtr_pkg::sts_type sts,
   output gtr_pkg::rsp_type rsp_item
);
   import gtr_pkg::*;

   logic [9:0] period_ms_ff;
   req_type item_ff;
   logic [62:0] p_ff, exp_ff, prev_ff, last_ff;
   logic [62:0] num_ff, rem_ff, quo_ff, mcand_ff, prod_ff;
   logic [5:0] cnt_ff;
   logic [62:0] room_ff;
   logic second_ff;
   rsp_type rsp_ff;

   logic [9:0] pm;
   logic [29:0] pns;
   logic [63:0] trial;
   logic [62:0] t;
   logic [63:0] sum64;

   assign pm = (period_ms_ff == 10'd0) ? 10'd1 : period_ms_ff;
   assign pns = 30'(pm) * 30'(NsPerMs);
   assign t = item_ff.time_ns;
   assign trial = {rem_ff, num_ff[62]} - {1'b0, p_ff};

   function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? TMax : s[62:0];
   endfunction

   function automatic logic signed [15:0] clamp(input logic signed [16:0] v);
      if (v > RateLimit) return RateLimit[15:0];
      if (v < -RateLimit) return 16'(-RateLimit);
      return v[15:0];
   endfunction

   // needs_div: tick at or past expected or sample behind expected
   assign sts.needs_div = (item_ff.kind == KindTick && t >= exp_ff) ||
                          (item_ff.kind == KindSample && t > exp_ff);
   assign sts.is_none = !(item_ff.kind == KindStart || item_ff.kind == KindTick ||
                          item_ff.kind == KindSample);
   // a tick runs two divisions, a sample one
   assign sts.div_done = (cnt_ff == 6'd62) && (item_ff.kind != KindTick || second_ff);
   assign sts.mul_done = (cnt_ff == 6'd62);
   assign sum64 = {1'b0, prod_ff} + {1'b0, exp_ff};

   logic [62:0] t_corr, t_fin, half, back, d_lo;
   logic emit_c;
   always_comb begin
      half = {1'b0, p_ff[62:1]};
      d_lo = exp_ff - t;
      back = (d_lo > half + NearSlackNs) ? p_ff : half;
      if (exp_ff >= t) t_corr = (exp_ff > back) ? exp_ff - back : '0;
      else t_corr = sum64[62:0];
      t_fin = t_corr;
      if (item_ff.bias_mode) begin
         if (prev_ff >= t_corr) t_fin = prev_ff;
         else if (t_corr - prev_ff <= MinGapTestNs) t_fin = sat_add(prev_ff, MinGapNs);
      end
      emit_c = (item_ff.kind == KindSample) && (t_fin != last_ff);
   end
   assign sts.emit = emit_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ms_ff <= PeriodReset;
         exp_ff <= '0;
         prev_ff <= '0;
         last_ff <= '0;
         cnt_ff <= '0;
         second_ff <= 1'b0;
      end else begin
         if (csr_we) period_ms_ff <= csr_wdata;
         if (cmd.load) begin
            item_ff <= req_item;
            p_ff <= {33'd0, pns};
         end
         if (cmd.div_start) begin
            // tick: (t-exp)/p then room = (TMax-exp)/p; sample: (t-exp)/p
            num_ff <= t - exp_ff;
            rem_ff <= '0;
            cnt_ff <= '0;
            second_ff <= 1'b0;
         end
         if (cmd.div_step) begin
            if (cnt_ff == 6'd62 && item_ff.kind == KindTick && !second_ff) begin
               num_ff <= TMax - exp_ff;
               rem_ff <= '0;
            end else begin
               if (!trial[63]) rem_ff <= trial[62:0];
               else rem_ff <= {rem_ff[61:0], num_ff[62]};
               num_ff <= {num_ff[61:0], ~trial[63]};
            end
            if (cnt_ff == 6'd62) begin
               cnt_ff <= '0;
               if (item_ff.kind == KindTick && !second_ff) begin
                  second_ff <= 1'b1;
                  quo_ff <= {num_ff[61:0], ~trial[63]};
               end else begin
                  second_ff <= 1'b0;
                  if (item_ff.kind == KindTick) begin
                     room_ff <= {num_ff[61:0], ~trial[63]};
                     quo_ff <= quo_ff + 63'd1;
                  end else quo_ff <= {num_ff[61:0], ~trial[63]};
                  mcand_ff <= p_ff;
                  prod_ff <= '0;
               end
            end else cnt_ff <= cnt_ff + 6'd1;
         end
         if (cmd.mul_step) begin
            // shift-add over quotient bits, lsb first
            if (quo_ff[cnt_ff[5:0]]) prod_ff <= prod_ff + mcand_ff;
            mcand_ff <= mcand_ff << 1;
            cnt_ff <= (cnt_ff == 6'd62) ? '0 : cnt_ff + 6'd1;
         end
         if (cmd.finish) begin
            case (item_ff.kind)
               KindStart: begin
                  exp_ff <= sat_add(t, p_ff);
                  prev_ff <= t;
               end
               KindTick: begin
                  if (t >= exp_ff) begin
                     if (quo_ff > room_ff) exp_ff <= TMax;
                     else exp_ff <= sum64[62:0];
                  end else exp_ff <= sat_add(t, p_ff);
               end
               KindSample: begin
                  if (item_ff.bias_mode) prev_ff <= t_fin;
                  if (emit_c) begin
                     last_ff <= t_fin;
                     rsp_ff.out_x <= clamp(17'(item_ff.rate_x) -
                        (item_ff.bias_mode ? 17'(item_ff.bias_x) : 17'sd0));
                     rsp_ff.out_y <= clamp(17'(item_ff.rate_y) -
                        (item_ff.bias_mode ? 17'(item_ff.bias_y) : 17'sd0));
                     rsp_ff.out_z <= clamp(17'(item_ff.rate_z) -
                        (item_ff.bias_mode ? 17'(item_ff.bias_z) : 17'sd0));
                     rsp_ff.out_accuracy <= item_ff.accuracy;
                     rsp_ff.out_time_ns <= t_fin;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_item = rsp_ff;
endmodule

// ----- rtl/core/gtr_control.sv -----
// Controller: sequences load, divide, multiply and finish for one item.
module gtr_control (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   input gtr_pkg::sts_type sts,
   output gtr_pkg::cmd_type cmd
);
   import gtr_pkg::*;

   typedef enum logic [2:0] {IDLE, DECIDE, DIV, MUL, FIN, OUT} state_type;
   state_type state_ff;
   logic rsp_valid_ff;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load = req_valid && req_ready;
      cmd.div_start = (state_ff == DECIDE) && sts.needs_div;
      cmd.div_step = (state_ff == DIV);
      cmd.mul_step = (state_ff == MUL);
      // finish only once the result register is free or being taken
      cmd.finish = (state_ff == FIN) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) rsp_valid_ff <= sts.emit;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            IDLE: if (cmd.load) state_ff <= DECIDE;
            DECIDE: begin
               if (sts.is_none) state_ff <= IDLE;
               else if (sts.needs_div) state_ff <= DIV;
               else state_ff <= FIN;
            end
            DIV: if (sts.div_done && cmd.div_step) state_ff <= MUL;
            MUL: if (sts.mul_done) state_ff <= FIN;
            FIN: if (cmd.finish) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/core/gyro_timestamp_regularizer.sv -----
// Top level: gyro timestamp regularizer, controller plus datapath.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/ready    req_item (req_type)
//   rsp      out  rsp_valid/ready    rsp_item (rsp_type)
//   csr      in   csr_we             csr_wdata, period in ms
//
// Start, a tick before expected time, or a sample at or ahead of expected:
// DECIDE then FIN, without the divider; an unused kind DECIDE then IDLE.
// A tick at or past expected time runs two 63-step restoring divisions and
// a 63-step shift-add multiply; a sample behind the grid one division plus
// the multiply. The finish step registers the result and rsp_valid. Reset
// is synchronous; item, arithmetic and result registers are not reset.
// A held result lets the next item in but stalls its finish step until taken.
module gyro_timestamp_regularizer (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input gtr_pkg::req_type req_item,
   output logic rsp_valid,
   input logic rsp_ready,
   output gtr_pkg::rsp_type rsp_item,
   input logic csr_we,
   input logic [9:0] csr_wdata
);
   import gtr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence the item
   gtr_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   // compute and hold state
   gtr_datapath u_dp (
      .clock, .reset, .csr_we, .csr_wdata, .req_item, .cmd, .sts, .rsp_item
   );

   // a held result never changes before it is taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_item))
      else $error("result changed while stalled");
   // an offered result stays offered until taken
   a_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before taken");
   // commands are exclusive
   a_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_step, cmd.mul_step, cmd.finish}))
      else $error("overlapping commands");
endmodule
